/* sv/pvc_pkg.sv */
// Package for the plane volume classify unit: types, codes and widths shared
// by all pipeline stages. Depends on nothing.
package pvc_pkg;

  // Widths of the fixed-point operands.
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned NORMAL_W  = 16;
  localparam int unsigned RADIUS_W  = 31;
  localparam int unsigned FRAC_ALIGN = 14;
  localparam int unsigned PROD_W    = NORMAL_W + COORD_W;
  localparam int unsigned ACC_W     = PROD_W + 3;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_X     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_Y     = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_Z     = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_OFFSET = 4'd3;

  // Volume kinds.
  localparam logic KIND_BOX    = 1'b0;
  localparam logic KIND_SPHERE = 1'b1;

  // Classification result codes.
  typedef enum logic [1:0] {
    SIDE_FRONT = 2'd0,
    SIDE_BACK  = 2'd1,
    SIDE_CROSS = 2'd2
  } side_t;

  // Plane held in the configuration registers.
  typedef struct packed {
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
    logic signed [COORD_W-1:0]  plane_offset;
  } plane_t;

  // After corner selection: the point for the low distance and the far corner.
  typedef struct packed {
    logic                       kind;
    logic signed [COORD_W-1:0]  near_x;
    logic signed [COORD_W-1:0]  near_y;
    logic signed [COORD_W-1:0]  near_z;
    logic signed [COORD_W-1:0]  far_x;
    logic signed [COORD_W-1:0]  far_y;
    logic signed [COORD_W-1:0]  far_z;
    logic [RADIUS_W-1:0]        radius;
  } corner_t;

  // Per-axis products.
  typedef struct packed {
    logic                       kind;
    logic signed [PROD_W-1:0]   near_px;
    logic signed [PROD_W-1:0]   near_py;
    logic signed [PROD_W-1:0]   near_pz;
    logic signed [PROD_W-1:0]   far_px;
    logic signed [PROD_W-1:0]   far_py;
    logic signed [PROD_W-1:0]   far_pz;
    logic [RADIUS_W-1:0]        radius;
  } product_t;

  // Signed distances, aligned to Q.30.
  typedef struct packed {
    logic                       kind;
    logic signed [ACC_W-1:0]    near_dist;
    logic signed [ACC_W-1:0]    far_dist;
    logic signed [ACC_W-1:0]    radius_scaled;
  } dist_t;

endpackage

/* sv/pvc_select.sv */
// First pipeline stage: picks the near and far box corners from the normal
// signs, or the sphere center. Depends on pvc_pkg.
module pvc_select (
  input  logic                 clk,
  input  logic                 rst,
  input  pvc_pkg::plane_t      plane,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 kind,
  input  logic signed [31:0]   box_min_x,
  input  logic signed [31:0]   box_min_y,
  input  logic signed [31:0]   box_min_z,
  input  logic signed [31:0]   box_max_x,
  input  logic signed [31:0]   box_max_y,
  input  logic signed [31:0]   box_max_z,
  input  logic signed [31:0]   center_x,
  input  logic signed [31:0]   center_y,
  input  logic signed [31:0]   center_z,
  input  logic [30:0]          sphere_radius,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pvc_pkg::corner_t     out_data
);

  logic             valid;
  pvc_pkg::corner_t data;
  pvc_pkg::corner_t data_next;
  logic             pos_x;
  logic             pos_y;
  logic             pos_z;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // A zero component counts as non-negative, so min is the near corner.
  always_comb begin
    pos_x = !plane.normal_x[pvc_pkg::NORMAL_W-1];
    pos_y = !plane.normal_y[pvc_pkg::NORMAL_W-1];
    pos_z = !plane.normal_z[pvc_pkg::NORMAL_W-1];
    data_next.kind   = kind;
    data_next.radius = sphere_radius;
    data_next.far_x  = pos_x ? box_max_x : box_min_x;
    data_next.far_y  = pos_y ? box_max_y : box_min_y;
    data_next.far_z  = pos_z ? box_max_z : box_min_z;
    if (kind == pvc_pkg::KIND_SPHERE) begin
      data_next.near_x = center_x;
      data_next.near_y = center_y;
      data_next.near_z = center_z;
    end else begin
      data_next.near_x = pos_x ? box_min_x : box_max_x;
      data_next.near_y = pos_y ? box_min_y : box_max_y;
      data_next.near_z = pos_z ? box_min_z : box_max_z;
    end
  end

  // Stage register; it moves whenever the next stage has room.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

/* sv/pvc_dot.sv */
// Second and third pipeline stages: the six normal-by-coordinate products,
// then the two plane distances and the scaled radius. Depends on pvc_pkg.
module pvc_dot (
  input  logic                 clk,
  input  logic                 rst,
  input  pvc_pkg::plane_t      plane,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pvc_pkg::corner_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pvc_pkg::dist_t       out_data
);

  localparam int unsigned PW = pvc_pkg::PROD_W;
  localparam int unsigned AW = pvc_pkg::ACC_W;

  logic              prod_valid;
  logic              prod_ready;
  pvc_pkg::product_t prod;
  pvc_pkg::product_t prod_next;
  logic              distance_valid;
  pvc_pkg::dist_t    distance;
  pvc_pkg::dist_t    distance_next;
  logic signed [AW-1:0] offset_scaled;

  assign prod_ready = !distance_valid || out_ready;
  assign in_ready   = !prod_valid || prod_ready;
  assign out_valid  = distance_valid;
  assign out_data   = distance;

  // Products are 16 by 32 bits and exact in 48 bits.
  always_comb begin
    prod_next.kind    = in_data.kind;
    prod_next.radius  = in_data.radius;
    prod_next.near_px = PW'(plane.normal_x) * PW'(in_data.near_x);
    prod_next.near_py = PW'(plane.normal_y) * PW'(in_data.near_y);
    prod_next.near_pz = PW'(plane.normal_z) * PW'(in_data.near_z);
    prod_next.far_px  = PW'(plane.normal_x) * PW'(in_data.far_x);
    prod_next.far_py  = PW'(plane.normal_y) * PW'(in_data.far_y);
    prod_next.far_pz  = PW'(plane.normal_z) * PW'(in_data.far_z);
  end

  // Sums of the products plus the offset, all aligned to Q.30.
  always_comb begin
    offset_scaled = {{(AW - pvc_pkg::COORD_W - pvc_pkg::FRAC_ALIGN)
                      {plane.plane_offset[pvc_pkg::COORD_W-1]}},
                     plane.plane_offset, {pvc_pkg::FRAC_ALIGN{1'b0}}};
    distance_next.kind      = prod.kind;
    distance_next.near_dist = AW'(prod.near_px) + AW'(prod.near_py) + AW'(prod.near_pz)
                            + offset_scaled;
    distance_next.far_dist  = AW'(prod.far_px) + AW'(prod.far_py) + AW'(prod.far_pz)
                            + offset_scaled;
    distance_next.radius_scaled = {{(AW - pvc_pkg::RADIUS_W - pvc_pkg::FRAC_ALIGN){1'b0}},
                                   prod.radius, {pvc_pkg::FRAC_ALIGN{1'b0}}};
  end

  // Product stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      prod <= prod_next;
    end
  end

  // Distance stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_valid <= 1'b0;
    end else if (prod_ready) begin
      distance_valid <= prod_valid;
    end
    if (prod_ready && prod_valid) begin
      distance <= distance_next;
    end
  end

endmodule

/* sv/pvc_decide.sv */
// Last pipeline stage: compares the distances and holds the result in the
// output register. Depends on pvc_pkg.
module pvc_decide (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pvc_pkg::dist_t       in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pvc_pkg::side_t       out_side
);

  logic           valid;
  pvc_pkg::side_t side;
  pvc_pkg::side_t side_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_side  = side;

  // Box: near corner in front, or far corner behind. Sphere: distance
  // against plus and minus the radius.
  always_comb begin
    if (in_data.kind == pvc_pkg::KIND_SPHERE) begin
      if (in_data.near_dist > in_data.radius_scaled) begin
        side_next = pvc_pkg::SIDE_FRONT;
      end else if (in_data.near_dist < -in_data.radius_scaled) begin
        side_next = pvc_pkg::SIDE_BACK;
      end else begin
        side_next = pvc_pkg::SIDE_CROSS;
      end
    end else begin
      if (in_data.near_dist > 0) begin
        side_next = pvc_pkg::SIDE_FRONT;
      end else if (in_data.far_dist < 0) begin
        side_next = pvc_pkg::SIDE_BACK;
      end else begin
        side_next = pvc_pkg::SIDE_CROSS;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      side <= side_next;
    end
  end

endmodule

/* sv/plane_volume_classify_unit.sv */
// Top level of the plane volume classify unit: plane registers and the
// four-stage pipeline. Depends on pvc_pkg, pvc_select, pvc_dot, pvc_decide.
//
//   Channel   Handshake                  Payload
//   volume    volume_valid/volume_stall  kind, box corners, center, radius
//   result    result_valid/result_stall  side
//   config    cfg_we                     cfg_index, cfg_data
//
// One transaction enters per cycle while volume_stall is low; the result
// passes through the select, product, sum and compare stages, the last
// being the output register. Throughput is one transaction per cycle
// while the result side does not stall, since every stage is registered.
// Reset clears all stage valid bits and the plane registers to zero.
// A stall on the result side holds each full stage; stages with a hole
// still advance, so stalls lose and repeat nothing.
module plane_volume_classify_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pvc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pvc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              volume_valid,
  output logic                              volume_stall,
  input  logic                              kind,
  input  logic signed [31:0]                box_min_x,
  input  logic signed [31:0]                box_min_y,
  input  logic signed [31:0]                box_min_z,
  input  logic signed [31:0]                box_max_x,
  input  logic signed [31:0]                box_max_y,
  input  logic signed [31:0]                box_max_z,
  input  logic signed [31:0]                center_x,
  input  logic signed [31:0]                center_y,
  input  logic signed [31:0]                center_z,
  input  logic [30:0]                       sphere_radius,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [1:0]                        side
);

  pvc_pkg::plane_t  plane;
  logic             sel_ready;
  logic             sel_valid;
  pvc_pkg::corner_t sel_data;
  logic             dot_ready;
  logic             dot_valid;
  pvc_pkg::dist_t   dot_data;
  logic             dec_ready;
  pvc_pkg::side_t   dec_side;

  // Plane registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      plane <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pvc_pkg::REG_NORMAL_X:     plane.normal_x     <= cfg_data[pvc_pkg::NORMAL_W-1:0];
        pvc_pkg::REG_NORMAL_Y:     plane.normal_y     <= cfg_data[pvc_pkg::NORMAL_W-1:0];
        pvc_pkg::REG_NORMAL_Z:     plane.normal_z     <= cfg_data[pvc_pkg::NORMAL_W-1:0];
        pvc_pkg::REG_PLANE_OFFSET: plane.plane_offset <= cfg_data[pvc_pkg::COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign volume_stall = !sel_ready;

  // Corner selection.
  pvc_select u_select (
    .clk           (clk),
    .rst           (rst),
    .plane         (plane),
    .in_valid      (volume_valid),
    .in_ready      (sel_ready),
    .kind          (kind),
    .box_min_x     (box_min_x),
    .box_min_y     (box_min_y),
    .box_min_z     (box_min_z),
    .box_max_x     (box_max_x),
    .box_max_y     (box_max_y),
    .box_max_z     (box_max_z),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .sphere_radius (sphere_radius),
    .out_valid     (sel_valid),
    .out_ready     (dot_ready),
    .out_data      (sel_data)
  );

  // Products and plane distances.
  pvc_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .plane     (plane),
    .in_valid  (sel_valid),
    .in_ready  (dot_ready),
    .in_data   (sel_data),
    .out_valid (dot_valid),
    .out_ready (dec_ready),
    .out_data  (dot_data)
  );

  // Classification and output register.
  pvc_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dot_valid),
    .in_ready  (dec_ready),
    .in_data   (dot_data),
    .out_valid (result_valid),
    .out_ready (!result_stall),
    .out_side  (dec_side)
  );

  assign side = dec_side;

endmodule
